// ===== hw/rtl/lbm_pkg.sv =====
// Shared types, constants and helper functions for the Lorentz boost block.
// Used by the square root and divider cells and by the top level.
// No dependencies.
package lbm_pkg;

  localparam int SqrtSteps = 32;
  localparam int DivSteps = 61;
  localparam int ChainLen = SqrtSteps + DivSteps;

  localparam logic [63:0] OneQ60 = 64'h1000_0000_0000_0000;
  localparam logic [31:0] OneQ30 = 32'h4000_0000;
  localparam logic [62:0] MagMax = '1;

  typedef struct packed {
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic [30:0]        rest_mass;
    logic signed [31:0] beta_x;
    logic signed [31:0] beta_y;
    logic signed [31:0] beta_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_mom_x;
    logic signed [31:0] out_mom_y;
    logic signed [31:0] out_mom_z;
    logic               beta_invalid;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] dvs;
    logic [31:0] rem;
    logic        lead;
    logic [60:0] quo;
  } div_t;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] b;
    logic [63:0]      bp;
    logic             b2zero;
    logic             invalid;
  } side_t;

  // Shifted product magnitude, clamped to the largest positive 64-bit value.
  function automatic logic [62:0] mag_shift(input logic [127:0] prod, input int sh);
    logic [127:0] q;
    q = prod >> sh;
    mag_shift = (|q[127:63]) ? MagMax : q[62:0];
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    abs64 = v[63] ? 64'(-v) : v;
  endfunction

endpackage

// ===== hw/rtl/lorentz_boost_momentum.sv =====
// Top level of the Lorentz boost block: input products, square root and divider cell
// chains, wide multiplier stages and a two-entry result buffer.
// Depends on lbm_pkg, lbm_sqrt_cell, lbm_div_cell and lbm_mul64.
//
// Usage: one particle per transaction on the item channel (momentum, rest mass and
// boost velocity), one boosted momentum per transaction on the result channel, in
// order. Both channels use valid/ready.
// Throughput is one transaction per cycle while the result buffer has room. Between
// acceptance and result_valid lie: products registered at acceptance, registered sums,
// 32 square root cells, 61 divider cells producing gamma and its helper quotient, three
// multiplier stages, one signing stage and the push into the result buffer.
// The whole pipeline advances together while the result buffer has room. With one
// result waiting and the receiver stalled, items are still accepted; when the buffer
// holds two results the pipeline freezes and item_ready is low until one is taken.
// item_ready depends only on registered state.
// Reset (synchronous, active high) empties the pipeline and the buffer; no clearing
// pass is needed and the block can accept a transaction in the first cycle after reset.
module lorentz_boost_momentum import lbm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int Last = ChainLen + 8;

  logic            en;
  logic            push;
  logic            pop;
  logic [1:0]      cnt;
  logic [Last:0]   vld;
  result_t         ob [0:1];
  result_t         res;

  logic [2:0][31:0] in_p;
  logic [2:0][31:0] in_b;
  logic [2:0][31:0] a_p;
  logic [2:0][31:0] a_b;
  logic [2:0][63:0] a_bb;
  logic [2:0][63:0] a_pp;
  logic [2:0][63:0] a_bp;
  logic [61:0]      a_mm;

  logic [63:0] b2_sum;
  logic [63:0] esq_sum;
  logic [63:0] bp_sum;
  sqrt_t       b_sqe;
  sqrt_t       b_sqs;

  sqrt_t sqe [0:SqrtSteps];
  sqrt_t sqs [0:SqrtSteps];
  div_t  dvg [0:DivSteps];
  div_t  dvh [0:DivSteps];
  side_t side_c [0:ChainLen];
  logic [31:0] e_d [1:DivSteps];

  side_t       t_side [1:7];
  logic [31:0] e_t [1:2];

  logic [127:0] g2m_p;
  logic [127:0] gbm_p [0:2];
  logic [127:0] gbpm_p;
  logic [127:0] t2m_p [0:2];
  logic [127:0] t1m_p [0:2];

  logic [62:0] g2;
  logic [62:0] gb_mag [0:2];
  logic [62:0] gbp_mag;
  logic [62:0] t2_mag [0:2];
  logic [62:0] t2_q1 [0:2];
  logic [62:0] t2_q2 [0:2];
  logic [62:0] t1_mag [0:2];
  logic signed [63:0] r_t1 [0:2];
  logic signed [63:0] r_t2 [0:2];
  logic signed [65:0] vsum [0:2];
  logic [2:0][31:0]   clip;
  logic [2:0]         over;

  assign en = cnt != 2'd2;
  assign item_ready = en;
  assign push = en && vld[Last];
  assign pop = result_valid && result_ready;
  assign result_valid = cnt != 2'd0;
  assign result = ob[0];

  assign in_p = {item.mom_z, item.mom_y, item.mom_x};
  assign in_b = {item.beta_z, item.beta_y, item.beta_x};

  always_ff @(posedge clk) begin
    if (en) begin
      a_p <= in_p;
      a_b <= in_b;
      a_mm <= item.rest_mass * item.rest_mass;
      for (int i = 0; i < 3; i++) begin
        a_bb[i] <= $signed(in_b[i]) * $signed(in_b[i]);
        a_pp[i] <= $signed(in_p[i]) * $signed(in_p[i]);
        a_bp[i] <= $signed(in_b[i]) * $signed(in_p[i]);
      end
    end
  end

  assign b2_sum = a_bb[0] + a_bb[1] + a_bb[2];
  assign esq_sum = 64'(a_mm) + a_pp[0] + a_pp[1] + a_pp[2];
  assign bp_sum = a_bp[0] + a_bp[1] + a_bp[2];

  always_ff @(posedge clk) begin
    if (en) begin
      b_sqe <= '{rad: esq_sum, rem: '0, root: '0};
      b_sqs <= '{rad: 64'(OneQ60 - b2_sum), rem: '0, root: '0};
      side_c[0] <= '{p: a_p, b: a_b, bp: bp_sum, b2zero: b2_sum == 64'd0,
                     invalid: b2_sum >= OneQ60};
      for (int k = 0; k < ChainLen; k++) begin
        side_c[k + 1] <= side_c[k];
      end
      e_d[1] <= sqe[SqrtSteps].root;
      for (int k = 1; k < DivSteps; k++) begin
        e_d[k + 1] <= e_d[k];
      end
    end
  end

  assign sqe[0] = b_sqe;
  assign sqs[0] = b_sqs;

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    lbm_sqrt_cell u_e (.clk(clk), .en(en), .prev(sqe[j]), .cur(sqe[j + 1]));
    lbm_sqrt_cell u_s (.clk(clk), .en(en), .prev(sqs[j]), .cur(sqs[j + 1]));
  end

  assign dvg[0] = '{dvs: sqs[SqrtSteps].root, rem: '0, lead: 1'b1, quo: '0};
  assign dvh[0] = '{dvs: 32'(OneQ30 + sqs[SqrtSteps].root), rem: '0, lead: 1'b1,
                    quo: '0};

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    lbm_div_cell u_g (.clk(clk), .en(en), .prev(dvg[j]), .cur(dvg[j + 1]));
    lbm_div_cell u_h (.clk(clk), .en(en), .prev(dvh[j]), .cur(dvh[j + 1]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_side[1] <= side_c[ChainLen];
      for (int k = 1; k < 7; k++) begin
        t_side[k + 1] <= t_side[k];
      end
      e_t[1] <= e_d[DivSteps];
      e_t[2] <= e_t[1];
      for (int i = 0; i < 3; i++) begin
        t2_q1[i] <= t2_mag[i];
        t2_q2[i] <= t2_q1[i];
        r_t1[i] <= (t_side[6].bp[63] ^ t_side[6].b[i][31]) ? 64'(-{1'b0, t1_mag[i]})
                                                            : {1'b0, t1_mag[i]};
        r_t2[i] <= t_side[6].b[i][31] ? 64'(-{1'b0, t2_q2[i]}) : {1'b0, t2_q2[i]};
      end
    end
  end

  lbm_mul64 u_g2 (
    .clk(clk), .en(en),
    .a({3'b000, dvg[DivSteps].quo}),
    .b({33'd0, dvh[DivSteps].quo[30:0]}),
    .prod(g2m_p)
  );

  assign g2 = t_side[2].b2zero ? '0 : mag_shift(g2m_p, 30);

  lbm_mul64 u_gbp (
    .clk(clk), .en(en),
    .a({1'b0, g2}),
    .b(abs64(t_side[2].bp)),
    .prod(gbpm_p)
  );

  assign gbp_mag = mag_shift(gbpm_p, 60);

  for (genvar i = 0; i < 3; i++) begin : g_lane
    lbm_mul64 u_gb (
      .clk(clk), .en(en),
      .a({3'b000, dvg[DivSteps].quo}),
      .b({32'd0, abs32(side_c[ChainLen].b[i])}),
      .prod(gbm_p[i])
    );

    assign gb_mag[i] = mag_shift(gbm_p[i], 30);

    lbm_mul64 u_t2 (
      .clk(clk), .en(en),
      .a({1'b0, gb_mag[i]}),
      .b({32'd0, e_t[2]}),
      .prod(t2m_p[i])
    );

    assign t2_mag[i] = mag_shift(t2m_p[i], 30);

    lbm_mul64 u_t1 (
      .clk(clk), .en(en),
      .a({1'b0, gbp_mag}),
      .b({32'd0, abs32(t_side[4].b[i])}),
      .prod(t1m_p[i])
    );

    assign t1_mag[i] = mag_shift(t1m_p[i], 30);

    assign vsum[i] = 66'(r_t1[i]) + 66'(r_t2[i]) + 66'($signed(t_side[7].p[i]));
    assign over[i] = !((&vsum[i][65:31]) || !(|vsum[i][65:31]));
    assign clip[i] = over[i] ? (vsum[i][65] ? 32'h8000_0000 : 32'h7fff_ffff)
                             : vsum[i][31:0];
  end

  always_comb begin
    if (t_side[7].invalid) begin
      res.out_mom_x = t_side[7].p[0];
      res.out_mom_y = t_side[7].p[1];
      res.out_mom_z = t_side[7].p[2];
      res.beta_invalid = 1'b1;
      res.saturated = 1'b0;
    end else begin
      res.out_mom_x = clip[0];
      res.out_mom_y = clip[1];
      res.out_mom_z = clip[2];
      res.beta_invalid = 1'b0;
      res.saturated = |over;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      vld <= '0;
    end else begin
      if (en) begin
        vld <= {vld[Last-1:0], item_valid};
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && (pop || cnt == 2'd0)) begin
      ob[0] <= res;
    end else if (pop) begin
      ob[0] <= ob[1];
    end
    if (push && !pop && cnt == 2'd1) begin
      ob[1] <= res;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result buffer count out of range");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.beta_invalid && result.saturated))
    else $error("beta_invalid and saturated both set");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + 2'd1)
    else $error("result buffer count did not follow a push");

  a_full_freeze: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |=> $stable(vld))
    else $error("pipeline moved while the result buffer was full");

endmodule

// ===== hw/rtl/lbm_sqrt_cell.sv =====
// One step of a digit-by-digit integer square root, two radicand bits per cell.
// Depends on lbm_pkg for the sqrt_t state type.
module lbm_sqrt_cell import lbm_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t prev,
  output sqrt_t cur
);

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        take;
  sqrt_t       nxt;

  always_comb begin
    rem_sh = {prev.rem, prev.rad[63:62]};
    trial = {2'b00, prev.root, 2'b01};
    take = rem_sh >= trial;
    nxt.rad = {prev.rad[61:0], 2'b00};
    nxt.rem = take ? 34'(rem_sh - trial) : rem_sh[33:0];
    nxt.root = {prev.root[30:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur <= nxt;
    end
  end

endmodule

// ===== hw/rtl/lbm_div_cell.sv =====
// One step of a restoring divider of 2^60 by a 32-bit divisor, one quotient bit per cell.
// Depends on lbm_pkg for the div_t state type.
module lbm_div_cell import lbm_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t prev,
  output div_t cur
);

  logic [32:0] rem_sh;
  logic        take;
  div_t        nxt;

  always_comb begin
    rem_sh = {prev.rem, prev.lead};
    take = rem_sh >= {1'b0, prev.dvs};
    nxt.dvs = prev.dvs;
    nxt.rem = take ? 32'(rem_sh - {1'b0, prev.dvs}) : rem_sh[31:0];
    nxt.lead = 1'b0;
    nxt.quo = {prev.quo[59:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur <= nxt;
    end
  end

endmodule

// ===== hw/rtl/lbm_mul64.sv =====
// Two-stage unsigned 64 by 64 multiplier built from four 32 by 32 partial products.
// No dependencies.
module lbm_mul64 (
  input  logic         clk,
  input  logic         en,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod
);

  logic [63:0] pp00;
  logic [63:0] pp01;
  logic [63:0] pp10;
  logic [63:0] pp11;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= a[31:0] * b[31:0];
      pp01 <= a[31:0] * b[63:32];
      pp10 <= a[63:32] * b[31:0];
      pp11 <= a[63:32] * b[63:32];
      prod <= {64'd0, pp00} + {32'd0, pp01, 32'd0} + {32'd0, pp10, 32'd0}
              + {pp11, 64'd0};
    end
  end

endmodule
